FILE: rtl/ppn_pkg.sv
// ============================================================================
// ppn_pkg: shared constants and tables for the periodic Perlin noise block
// Holds the fixed-point formats, pipeline sizing, register indexes and the
// 256-entry permutation table used by the lattice hash.
// ============================================================================
package ppn_pkg;

   localparam int FRAC_BITS = 12;
   localparam int INT_BITS  = 16;
   localparam int COORD_W   = INT_BITS + FRAC_BITS;
   localparam int PERIOD_W  = 9;
   localparam int NOISE_W   = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 9'h100;

   // 0.507 in Q16.
   localparam int SCALE_Q16 = 33227;
   localparam int SCALE_W   = 18;

   // Remainder unit: DIV_STEP restoring steps per pipeline stage.
   localparam int DIV_STEP = 4;
   localparam int DIV_STG  = (INT_BITS + DIV_STEP - 1) / DIV_STEP;
   localparam int DVD_W    = DIV_STG * DIV_STEP;
   localparam int REM_W    = PERIOD_W + 1;

   // Gradient dot products stay within three lattice units.
   localparam int DOT_W = FRAC_BITS + 3;

   // Input register, remainder stages, then eleven arithmetic stages.
   localparam int PIPE_STG = DIV_STG + 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PERIOD_X = 1'b0,
      CSR_PERIOD_Y = 1'b1
   } csr_index_type;

   localparam logic [7:0] PERM [256] = '{
      8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
      8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
      8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
      8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
      8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
      8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
      8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
      8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
      8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
      8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
      8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
      8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
      8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
      8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
      8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
      8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
      8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
      8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
      8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
      8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
      8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
      8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
      8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
      8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
      8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
      8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
      8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
      8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
      8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
      8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
      8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
      8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
   };

endpackage

FILE: rtl/ppn_req_if.sv
// ============================================================================
// ppn_req_if: coordinate channel
// Carries one 2D coordinate word with a valid/ready handshake.
// ============================================================================
interface ppn_req_if
   import ppn_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] coord_x;
   logic signed [COORD_W-1:0] coord_y;

   modport source (output valid, output coord_x, output coord_y, input ready);
   modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

FILE: rtl/ppn_rsp_if.sv
// ============================================================================
// ppn_rsp_if: noise sample channel
// Carries one noise sample word with a valid/ready handshake.
// ============================================================================
interface ppn_rsp_if
   import ppn_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [NOISE_W-1:0] noise_out;

   modport source (output valid, output noise_out, input ready);
   modport sink   (input valid, input noise_out, output ready);
endinterface

FILE: rtl/periodic_perlin_noise_2d_top.sv
// ============================================================================
// periodic_perlin_noise_2d_top: tileable 2D Perlin gradient noise
// Maps each signed Q.12 coordinate word to one saturated Q3.12 noise word.
// ============================================================================
//
//   channel  | dir | handshake         | word contents
//   ---------+-----+-------------------+---------------------------------
//   req_ch   | in  | valid/ready       | coord_x, coord_y (28b signed)
//   rsp_ch   | out | valid/ready       | noise_out (16b signed)
//   csr_*    | in  | csr_we, no wait   | csr_index, csr_wdata (periods)
//
// One word can enter every cycle while the output is not stalled. The pipeline is an
// input register, the restoring remainder stages that wrap the lattice cell, and
// the arithmetic stages of hashing, fade curve, blending and scaling.
// All stages advance together; a held output word stalls the whole pipe and only
// then drops req_ch.ready, so nothing is lost or repeated.
// Reset is synchronous, clears the valid bits and sets both periods to 256.
// ============================================================================
module periodic_perlin_noise_2d_top
   import ppn_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   ppn_req_if.sink              req_ch,
   ppn_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PERIOD_W-1:0]  csr_wdata
);

   localparam int F   = FRAC_BITS;
   localparam int PW  = 2 * F + 5;
   localparam int PRW = (F + 2) + (DOT_W + 1);
   localparam int SPW = DOT_W + SCALE_W;
   localparam int RW  = SPW + 1 - 16;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [DVD_W-1:0] dvd;
   } div_state_type;

   typedef struct packed {
      logic         negx;
      logic         negy;
      logic [7:0]   lx8;
      logic [7:0]   ly8;
      logic [F-1:0] fx;
      logic [F-1:0] fy;
   } carry_type;

   // Several restoring remainder steps: shift one dividend bit in, subtract
   // the period when it fits.
   function automatic div_state_type div_steps(div_state_type st,
                                               logic [PERIOD_W-1:0] p);
      div_state_type r;
      r = st;
      for (int k = 0; k < DIV_STEP; k++) begin
         r.rem = {r.rem[REM_W-2:0], r.dvd[DVD_W-1]};
         r.dvd = {r.dvd[DVD_W-2:0], 1'b0};
         if (r.rem >= {1'b0, p}) begin
            r.rem = r.rem - {1'b0, p};
         end
      end
      return r;
   endfunction

   // Wrapped low byte of the cell index and of its right/upper neighbor.
   // The remainder carries the sign of the index, as a truncating divide does.
   function automatic logic [15:0] wrap_pair(logic [PERIOD_W-1:0] rem,
                                             logic neg, logic [7:0] low8,
                                             logic [PERIOD_W-1:0] p);
      logic [7:0] i0;
      logic [7:0] i1;
      if (p == '0) begin
         i0 = low8;
         i1 = low8 + 8'd1;
      end else if (neg) begin
         i0 = 8'd0 - rem[7:0];
         i1 = (rem == '0) ? (8'd1 - p[7:0]) : (8'd1 - rem[7:0]);
      end else begin
         i0 = rem[7:0];
         i1 = (({1'b0, rem} + 1'b1) == {1'b0, p}) ? 8'd0 : (rem[7:0] + 8'd1);
      end
      return {i0, i1};
   endfunction

   // Dot product of one of eight gradients with the corner offset.
   function automatic logic signed [DOT_W-1:0] grad_dot(logic [2:0] h,
                                                        logic signed [F:0] dx,
                                                        logic signed [F:0] dy);
      logic signed [DOT_W-1:0] u;
      logic signed [DOT_W-1:0] v;
      logic signed [DOT_W-1:0] a;
      logic signed [DOT_W-1:0] b;
      u = h[2] ? DOT_W'(dy) : DOT_W'(dx);
      v = h[2] ? DOT_W'(dx) : DOT_W'(dy);
      a = h[0] ? -u : u;
      b = h[1] ? -(v <<< 1) : (v <<< 1);
      return a + b;
   endfunction

   // ---------------------------------------------------------------------
   // Control: periods and the valid bits that travel with each stage.
   // ---------------------------------------------------------------------
   logic [PERIOD_W-1:0] period_x_ff;
   logic [PERIOD_W-1:0] period_y_ff;
   logic [PIPE_STG-1:0] valid_ff;
   logic                adv;

   assign adv          = !valid_ff[PIPE_STG-1] || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign rsp_ch.valid = valid_ff[PIPE_STG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         period_x_ff <= PERIOD_RESET;
         period_y_ff <= PERIOD_RESET;
         valid_ff    <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_PERIOD_X: period_x_ff <= csr_wdata;
               CSR_PERIOD_Y: period_y_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (adv) begin
            valid_ff <= {valid_ff[PIPE_STG-2:0], req_ch.valid};
         end
      end
   end

   // ---------------------------------------------------------------------
   // Input register: split each coordinate into cell index and fraction.
   // ---------------------------------------------------------------------
   logic signed [INT_BITS-1:0] lx_in;
   logic signed [INT_BITS-1:0] ly_in;
   carry_type                  s0_car_in;
   carry_type                  s0_car_ff;
   logic [INT_BITS-1:0]        xmag_ff;
   logic [INT_BITS-1:0]        ymag_ff;

   always_comb begin
      lx_in          = req_ch.coord_x[COORD_W-1:F];
      ly_in          = req_ch.coord_y[COORD_W-1:F];
      s0_car_in.negx = lx_in[INT_BITS-1];
      s0_car_in.negy = ly_in[INT_BITS-1];
      s0_car_in.lx8  = lx_in[7:0];
      s0_car_in.ly8  = ly_in[7:0];
      s0_car_in.fx   = req_ch.coord_x[F-1:0];
      s0_car_in.fy   = req_ch.coord_y[F-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_car_ff <= s0_car_in;
         xmag_ff   <= lx_in[INT_BITS-1] ? (~lx_in + 1'b1) : lx_in;
         ymag_ff   <= ly_in[INT_BITS-1] ? (~ly_in + 1'b1) : ly_in;
      end
   end

   // ---------------------------------------------------------------------
   // Remainder unit: magnitude of each cell index modulo its period.
   // ---------------------------------------------------------------------
   div_state_type xdiv_ff [DIV_STG];
   div_state_type ydiv_ff [DIV_STG];
   carry_type     dcar_ff [DIV_STG];

   for (genvar g = 0; g < DIV_STG; g++) begin : g_div
      div_state_type xsrc;
      div_state_type ysrc;
      carry_type     csrc;
      if (g == 0) begin : g_first
         assign xsrc = '{rem: '0, dvd: DVD_W'(xmag_ff)};
         assign ysrc = '{rem: '0, dvd: DVD_W'(ymag_ff)};
         assign csrc = s0_car_ff;
      end else begin : g_next
         assign xsrc = xdiv_ff[g-1];
         assign ysrc = ydiv_ff[g-1];
         assign csrc = dcar_ff[g-1];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            xdiv_ff[g] <= div_steps(xsrc, period_x_ff);
            ydiv_ff[g] <= div_steps(ysrc, period_y_ff);
            dcar_ff[g] <= csrc;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Arithmetic stages.
   // ---------------------------------------------------------------------
   carry_type      dlast;
   logic [15:0]    xw_in;
   logic [15:0]    yw_in;
   assign dlast = dcar_ff[DIV_STG-1];
   assign xw_in = wrap_pair(xdiv_ff[DIV_STG-1].rem[PERIOD_W-1:0], dlast.negx,
                            dlast.lx8, period_x_ff);
   assign yw_in = wrap_pair(ydiv_ff[DIV_STG-1].rem[PERIOD_W-1:0], dlast.negy,
                            dlast.ly8, period_y_ff);

   // Stage 1: wrapped corners, fraction squares.
   logic [7:0]     e1_x0_ff, e1_x1_ff, e1_y0_ff, e1_y1_ff;
   logic [2*F-1:0] e1_fsqx_ff, e1_fsqy_ff;
   logic [F-1:0]   e1_fx_ff, e1_fy_ff;

   // Stage 2: first hash level, fade terms a and p.
   logic [7:0]     e2_x0_ff, e2_x1_ff, e2_hy0_ff, e2_hy1_ff;
   logic [F:0]     e2_ax_ff, e2_ay_ff;
   logic [F+3:0]   e2_px_ff, e2_py_ff;
   logic [F-1:0]   e2_fx_ff, e2_fy_ff;
   logic [2*F:0]   ax_sum_in, ay_sum_in;
   logic [PW-1:0]  px_sum_in, py_sum_in;

   // Stage 3: corner hashes, a*f.
   logic [2:0]     e3_h00_ff, e3_h01_ff, e3_h10_ff, e3_h11_ff;
   logic [2*F:0]   e3_bprx_ff, e3_bpry_ff;
   logic [F+3:0]   e3_px_ff, e3_py_ff;
   logic [F-1:0]   e3_fx_ff, e3_fy_ff;

   // Stage 4: gradient dots, fade term b.
   logic signed [DOT_W-1:0] e4_d00_ff, e4_d01_ff, e4_d10_ff, e4_d11_ff;
   logic [F:0]     e4_bx_ff, e4_by_ff;
   logic [F+3:0]   e4_px_ff, e4_py_ff;
   logic [2*F+1:0] bx_sum_in, by_sum_in;
   logic signed [F:0] fx0_in, fx1_in, fy0_in, fy1_in;

   // Stage 5: fade products.
   logic [2*F+4:0] e5_fprx_ff, e5_fpry_ff;
   logic signed [DOT_W-1:0] e5_d00_ff, e5_d01_ff, e5_d10_ff, e5_d11_ff;

   // Stage 6: fade values, corner differences.
   logic [F:0]     e6_tf_ff, e6_sf_ff;
   logic signed [DOT_W:0]   e6_dif0_ff, e6_dif1_ff;
   logic signed [DOT_W-1:0] e6_d00_ff, e6_d10_ff;
   logic [2*F+5:0] sfx_sum_in, tfy_sum_in;

   // Stage 7: vertical blend products.
   logic signed [PRW-1:0]   e7_pr0_ff, e7_pr1_ff;
   logic signed [DOT_W-1:0] e7_d00_ff, e7_d10_ff;
   logic [F:0]     e7_sf_ff;

   // Stage 8: vertical blends.
   logic signed [DOT_W-1:0] e8_n0_ff, e8_n1_ff;
   logic [F:0]     e8_sf_ff;
   logic signed [PRW:0]     r0_sum_in, r1_sum_in;

   // Stage 9: horizontal blend product.
   logic signed [PRW-1:0]   e9_prn_ff;
   logic signed [DOT_W-1:0] e9_n0_ff;

   // Stage 10: blended value times 0.507.
   logic signed [SPW-1:0]   e10_prs_ff;
   logic signed [PRW:0]     rn_sum_in;
   logic signed [DOT_W-1:0] n_in;

   // Stage 11: output register.
   logic signed [NOISE_W-1:0] e11_noise_ff;
   logic signed [SPW:0]       rs_sum_in;
   logic signed [RW-1:0]      rs_in;
   logic signed [NOISE_W-1:0] noise_in;

   always_comb begin
      ax_sum_in = {1'b0, e1_fsqx_ff} + (2*F+1)'(1 << (F - 1));
      ay_sum_in = {1'b0, e1_fsqy_ff} + (2*F+1)'(1 << (F - 1));
      // 6f^2 - 15Sf + 10S^2 is positive on the whole fraction range.
      px_sum_in = PW'(6) * PW'(e1_fsqx_ff) + (PW'(10) << (2 * F))
                + PW'(1 << (F - 1)) - PW'(15) * (PW'(e1_fx_ff) << F);
      py_sum_in = PW'(6) * PW'(e1_fsqy_ff) + (PW'(10) << (2 * F))
                + PW'(1 << (F - 1)) - PW'(15) * (PW'(e1_fy_ff) << F);

      bx_sum_in = {1'b0, e3_bprx_ff} + (2*F+2)'(1 << (F - 1));
      by_sum_in = {1'b0, e3_bpry_ff} + (2*F+2)'(1 << (F - 1));
      fx0_in    = $signed({1'b0, e3_fx_ff});
      fy0_in    = $signed({1'b0, e3_fy_ff});
      fx1_in    = fx0_in - $signed((F+1)'(1 << F));
      fy1_in    = fy0_in - $signed((F+1)'(1 << F));

      sfx_sum_in = {1'b0, e5_fprx_ff} + (2*F+6)'(1 << (F - 1));
      tfy_sum_in = {1'b0, e5_fpry_ff} + (2*F+6)'(1 << (F - 1));

      r0_sum_in = (PRW+1)'(e7_pr0_ff) + $signed((PRW+1)'(1 << (F - 1)));
      r1_sum_in = (PRW+1)'(e7_pr1_ff) + $signed((PRW+1)'(1 << (F - 1)));

      rn_sum_in = (PRW+1)'(e9_prn_ff) + $signed((PRW+1)'(1 << (F - 1)));
      n_in      = e9_n0_ff + DOT_W'(rn_sum_in >>> F);

      rs_sum_in = (SPW+1)'(e10_prs_ff) + $signed((SPW+1)'(1 << 15));
      rs_in     = RW'(rs_sum_in >>> 16);
      if (rs_in > $signed(RW'(32767))) begin
         noise_in = 16'sh7fff;
      end else if (rs_in < $signed(-RW'(32768))) begin
         noise_in = -16'sh8000;
      end else begin
         noise_in = NOISE_W'(rs_in);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // Stage 1
         {e1_x0_ff, e1_x1_ff} <= xw_in;
         {e1_y0_ff, e1_y1_ff} <= yw_in;
         e1_fsqx_ff <= (2*F)'(dlast.fx) * (2*F)'(dlast.fx);
         e1_fsqy_ff <= (2*F)'(dlast.fy) * (2*F)'(dlast.fy);
         e1_fx_ff   <= dlast.fx;
         e1_fy_ff   <= dlast.fy;
         // Stage 2
         e2_x0_ff  <= e1_x0_ff;
         e2_x1_ff  <= e1_x1_ff;
         e2_hy0_ff <= PERM[e1_y0_ff];
         e2_hy1_ff <= PERM[e1_y1_ff];
         e2_ax_ff  <= ax_sum_in[2*F:F];
         e2_ay_ff  <= ay_sum_in[2*F:F];
         e2_px_ff  <= px_sum_in[2*F+3:F];
         e2_py_ff  <= py_sum_in[2*F+3:F];
         e2_fx_ff  <= e1_fx_ff;
         e2_fy_ff  <= e1_fy_ff;
         // Stage 3
         e3_h00_ff  <= PERM[8'(e2_x0_ff + e2_hy0_ff)][2:0];
         e3_h01_ff  <= PERM[8'(e2_x0_ff + e2_hy1_ff)][2:0];
         e3_h10_ff  <= PERM[8'(e2_x1_ff + e2_hy0_ff)][2:0];
         e3_h11_ff  <= PERM[8'(e2_x1_ff + e2_hy1_ff)][2:0];
         e3_bprx_ff <= (2*F+1)'(e2_ax_ff) * (2*F+1)'(e2_fx_ff);
         e3_bpry_ff <= (2*F+1)'(e2_ay_ff) * (2*F+1)'(e2_fy_ff);
         e3_px_ff   <= e2_px_ff;
         e3_py_ff   <= e2_py_ff;
         e3_fx_ff   <= e2_fx_ff;
         e3_fy_ff   <= e2_fy_ff;
         // Stage 4
         e4_d00_ff <= grad_dot(e3_h00_ff, fx0_in, fy0_in);
         e4_d01_ff <= grad_dot(e3_h01_ff, fx0_in, fy1_in);
         e4_d10_ff <= grad_dot(e3_h10_ff, fx1_in, fy0_in);
         e4_d11_ff <= grad_dot(e3_h11_ff, fx1_in, fy1_in);
         e4_bx_ff  <= bx_sum_in[2*F:F];
         e4_by_ff  <= by_sum_in[2*F:F];
         e4_px_ff  <= e3_px_ff;
         e4_py_ff  <= e3_py_ff;
         // Stage 5
         e5_fprx_ff <= (2*F+5)'(e4_bx_ff) * (2*F+5)'(e4_px_ff);
         e5_fpry_ff <= (2*F+5)'(e4_by_ff) * (2*F+5)'(e4_py_ff);
         e5_d00_ff  <= e4_d00_ff;
         e5_d01_ff  <= e4_d01_ff;
         e5_d10_ff  <= e4_d10_ff;
         e5_d11_ff  <= e4_d11_ff;
         // Stage 6
         e6_sf_ff   <= sfx_sum_in[2*F:F];
         e6_tf_ff   <= tfy_sum_in[2*F:F];
         e6_dif0_ff <= (DOT_W+1)'(e5_d01_ff) - (DOT_W+1)'(e5_d00_ff);
         e6_dif1_ff <= (DOT_W+1)'(e5_d11_ff) - (DOT_W+1)'(e5_d10_ff);
         e6_d00_ff  <= e5_d00_ff;
         e6_d10_ff  <= e5_d10_ff;
         // Stage 7
         e7_pr0_ff <= PRW'($signed({1'b0, e6_tf_ff})) * PRW'(e6_dif0_ff);
         e7_pr1_ff <= PRW'($signed({1'b0, e6_tf_ff})) * PRW'(e6_dif1_ff);
         e7_d00_ff <= e6_d00_ff;
         e7_d10_ff <= e6_d10_ff;
         e7_sf_ff  <= e6_sf_ff;
         // Stage 8
         e8_n0_ff <= e7_d00_ff + DOT_W'(r0_sum_in >>> F);
         e8_n1_ff <= e7_d10_ff + DOT_W'(r1_sum_in >>> F);
         e8_sf_ff <= e7_sf_ff;
         // Stage 9
         e9_prn_ff <= PRW'($signed({1'b0, e8_sf_ff}))
                    * (PRW'(e8_n1_ff) - PRW'(e8_n0_ff));
         e9_n0_ff  <= e8_n0_ff;
         // Stage 10
         e10_prs_ff <= SPW'(n_in) * $signed(SPW'(SCALE_Q16));
         // Stage 11
         e11_noise_ff <= noise_in;
      end
   end

   assign rsp_ch.noise_out = e11_noise_ff;

endmodule

FILE: rtl/ppn_chk.sv
// ============================================================================
// ppn_chk: port-level checks for the periodic Perlin noise block
// Watches the two channels of the top level and is attached by a bind.
// ============================================================================
module ppn_chk
   import ppn_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [NOISE_W-1:0] noise_out
);

   // The input side backs off only while a finished word is held up.
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without an output stall");

   // Leaving reset, no word is presented.
   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid)
      else $error("output word present right after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("output word dropped while stalled");

   a_data_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(noise_out))
      else $error("output word changed while stalled");

endmodule

bind periodic_perlin_noise_2d_top ppn_chk u_ppn_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .noise_out (rsp_ch.noise_out)
);
